// ----- design/fird_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fird_pkg
// Shared constants, types and the coefficient table of the low-pass filter
// with DC bias removal.
// ----------------------------------------------------------------------------
package fird_pkg;

  // Default configuration of the block.
  localparam int TAPS_DEF        = 51;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int BIAS_BLOCK_DEF  = 35;

  // Coefficient format: signed Q1.15.
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 8;
  localparam int Q_SHIFT    = 15;
  localparam int Q_ROUND    = 32767;

  // Result field widths and the filter output range.
  localparam int FILT_W   = 14;
  localparam int CENT_W   = 15;
  localparam int FILT_MAX = 8191;
  localparam int FILT_MIN = -8192;

  // The output scale 1000/1240 reduced to lowest terms.
  localparam int SCALE_NUM = 25;
  localparam int SCALE_DEN = 31;

  // Constant divider: operand width and divisor width.
  localparam int DIV_W  = 20;
  localparam int DIV_DW = 6;

  // Divisor select codes.
  localparam logic DIV_SEL_BIAS  = 1'b0;
  localparam logic DIV_SEL_SCALE = 1'b1;

  // Request from the control to the constant divider.
  typedef struct packed {
    logic start;
    logic sel;
  } div_req_t;

  // Accumulator width for a given tap count and sample width.
  function automatic int acc_width(input int taps, input int sample_bits);
    acc_width = sample_bits + COEF_W + $clog2(taps) + 1;
  endfunction

  // Low-pass coefficients; taps past the table read as zero.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      8'd0:    c = -16'sd248;
      8'd1:    c = -16'sd62;
      8'd2:    c = 16'sd162;
      8'd3:    c = 16'sd431;
      8'd4:    c = 16'sd538;
      8'd5:    c = 16'sd351;
      8'd6:    c = -16'sd38;
      8'd7:    c = -16'sd342;
      8'd8:    c = -16'sd297;
      8'd9:    c = 16'sd91;
      8'd10:   c = 16'sd499;
      8'd11:   c = 16'sd527;
      8'd12:   c = 16'sd56;
      8'd13:   c = -16'sd574;
      8'd14:   c = -16'sd789;
      8'd15:   c = -16'sd274;
      8'd16:   c = 16'sd660;
      8'd17:   c = 16'sd1211;
      8'd18:   c = 16'sd708;
      8'd19:   c = -16'sd722;
      8'd20:   c = -16'sd2005;
      8'd21:   c = -16'sd1744;
      8'd22:   c = 16'sd763;
      8'd23:   c = 16'sd4832;
      8'd24:   c = 16'sd8610;
      8'd25:   c = 16'sd10146;
      8'd26:   c = 16'sd8610;
      8'd27:   c = 16'sd4832;
      8'd28:   c = 16'sd763;
      8'd29:   c = -16'sd1744;
      8'd30:   c = -16'sd2005;
      8'd31:   c = -16'sd722;
      8'd32:   c = 16'sd708;
      8'd33:   c = 16'sd1211;
      8'd34:   c = 16'sd660;
      8'd35:   c = -16'sd274;
      8'd36:   c = -16'sd789;
      8'd37:   c = -16'sd574;
      8'd38:   c = 16'sd56;
      8'd39:   c = 16'sd527;
      8'd40:   c = 16'sd499;
      8'd41:   c = 16'sd91;
      8'd42:   c = -16'sd297;
      8'd43:   c = -16'sd342;
      8'd44:   c = 16'sd351;
      8'd45:   c = 16'sd538;
      8'd46:   c = 16'sd431;
      8'd47:   c = 16'sd162;
      8'd48:   c = -16'sd62;
      8'd49:   c = -16'sd248;
      8'd50:   c = -16'sd248;
      default: c = '0;
    endcase
    coef_at = c;
  endfunction

endpackage
`default_nettype wire

// ----- design/fird_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fird_mac
// Delay line held in a circular memory, swept one tap per cycle through a
// registered multiply and accumulate.
// ----------------------------------------------------------------------------
module fird_mac
  import fird_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        done_o,
  output logic signed [acc_width(TAPS, SAMPLE_BITS)-1:0] acc_o
);

  localparam int ACC_W = acc_width(TAPS, SAMPLE_BITS);
  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FW    = $clog2(TAPS + 1);
  localparam int PW    = SAMPLE_BITS + 1 + COEF_W;
  localparam logic [AW-1:0] LAST  = AW'(TAPS - 1);
  localparam logic [FW-1:0] FULL  = FW'(TAPS);

  logic [SAMPLE_BITS-1:0] mem [TAPS];

  logic [AW-1:0]            wp_q, rp_q, k_q;
  logic [FW-1:0]            fill_q;
  logic                     run_q;
  logic                     s1_vld_q, s1_last_q, s1_ok_q;
  logic signed [COEF_W-1:0] s1_coef_q;
  logic [SAMPLE_BITS-1:0]   rd_q;
  logic                     s2_vld_q, s2_last_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done_q;
  logic signed [SAMPLE_BITS:0] tap_s;

  // Sample memory: the new word is written at the head, taps are read back
  // newest first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mem[wp_q] <= sample_i;
    end
    if (run_q) begin
      rd_q <= mem[rp_q];
    end
  end

  // Pointers, fill count and the tap sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      k_q    <= '0;
      fill_q <= '0;
      run_q  <= 1'b0;
    end else if (start_i) begin
      rp_q   <= wp_q;
      wp_q   <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
      k_q    <= '0;
      run_q  <= 1'b1;
      if (fill_q != FULL) begin
        fill_q <= fill_q + 1'b1;
      end
    end else if (run_q) begin
      rp_q <= (rp_q == '0) ? LAST : rp_q - 1'b1;
      k_q  <= k_q + 1'b1;
      if (k_q == LAST) begin
        run_q <= 1'b0;
      end
    end
  end

  // First stage: coefficient and a flag for taps that were never written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= run_q;
      s1_last_q <= run_q && (k_q == LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q   <= FW'(k_q) < fill_q;
    s1_coef_q <= coef_at(COEF_IDX_W'(k_q));
  end

  assign tap_s = s1_ok_q ? $signed({1'b0, rd_q}) : '0;

  // Second stage: product of one tap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_vld_q && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= tap_s * s1_coef_q;
  end

  // Third stage: accumulate, flag the sum as done after the last tap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= s2_vld_q && s2_last_q;
      if (start_i) begin
        acc_q <= '0;
      end else if (s2_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

// ----- design/fird_cdiv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fird_cdiv
// Unsigned division by one of two constants: multiply by a scaled
// reciprocal, then a single compare and subtract correction.
// ----------------------------------------------------------------------------
module fird_cdiv
  import fird_pkg::*;
#(
  parameter int BIAS_BLOCK = BIAS_BLOCK_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_req_t         req_i,
  input  wire logic [DIV_W-1:0] x_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quo_o
);

  localparam int MW = DIV_W + 1;
  localparam int PW = DIV_W + MW;
  localparam logic [MW-1:0]     M_BIAS  = MW'((1 << DIV_W) / BIAS_BLOCK);
  localparam logic [MW-1:0]     M_SCALE = MW'((1 << DIV_W) / SCALE_DEN);
  localparam logic [DIV_DW-1:0] D_BIAS  = DIV_DW'(BIAS_BLOCK);
  localparam logic [DIV_DW-1:0] D_SCALE = DIV_DW'(SCALE_DEN);

  logic [3:0]              vld_q;
  logic [DIV_W-1:0]        x_q;
  logic [DIV_DW-1:0]       d_q;
  logic [MW-1:0]           m_q;
  logic [PW-1:0]           p_q;
  logic [DIV_W-1:0]        q0_q, qd_q, quo_q;
  logic [DIV_W-1:0]        q0_w, rem_w;
  logic [DIV_W+DIV_DW-1:0] qd_full;

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_i.start};
    end
  end

  // Operand capture and divisor selection.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= x_i;
      d_q <= (req_i.sel == DIV_SEL_SCALE) ? D_SCALE : D_BIAS;
      m_q <= (req_i.sel == DIV_SEL_SCALE) ? M_SCALE : M_BIAS;
    end
  end

  // The estimate is the true quotient or one less; the remainder decides.
  assign q0_w    = p_q[DIV_W +: DIV_W];
  assign qd_full = q0_w * d_q;
  assign rem_w   = x_q - qd_q;

  always_ff @(posedge clk_i) begin
    p_q  <= x_q * m_q;
    q0_q <= q0_w;
    qd_q <= qd_full[DIV_W-1:0];
    if (vld_q[2]) begin
      quo_q <= (rem_w >= DIV_W'(d_q)) ? q0_q + 1'b1 : q0_q;
    end
  end

  assign done_o = vld_q[3];
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ----- design/fir_lowpass_dc_removal_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fir_lowpass_dc_removal_top
// Low-pass FIR on converter samples with block-wise DC bias removal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one sample word. Output
//   channel: out_valid_o / out_stall_i carry the filtered value, the bias in
//   use and the centered value (filtered minus bias, scaled by 1000/1240).
//   Each accepted word gives exactly one result word.
//   One word is processed at a time. The filter sweeps the delay line one
//   tap per cycle from its sample memory; after the sweep come the multiply
//   pipeline, the sequencer steps and the scale division. The next word can
//   be taken in idle, which the engine enters as the result is loaded. A
//   word that closes a bias block also passes through the bias division.
//   in_stall_o is low whenever the engine is idle; the next word is taken
//   while the previous result still waits in the output register.
//   When the receiver stalls, the result holds and the engine waits with its
//   finished result until the output register frees.
//   Reset clears the delay line (through a fill count), the bias sum, the
//   block count and the bias, and empties the output register.
// ----------------------------------------------------------------------------
module fir_lowpass_dc_removal_top
  import fird_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int BIAS_BLOCK  = BIAS_BLOCK_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [FILT_W-1:0]      filtered_o,
  output logic signed [FILT_W-1:0]      bias_o,
  output logic signed [CENT_W-1:0]      centered_o
);

  localparam int ACC_W = acc_width(TAPS, SAMPLE_BITS);
  localparam int CW    = $clog2(BIAS_BLOCK + 1);
  localparam int SUM_W = FILT_W + CW;
  localparam logic signed [ACC_W-1:0] F_HI = ACC_W'(FILT_MAX);
  localparam logic signed [ACC_W-1:0] F_LO = ACC_W'(FILT_MIN);
  localparam logic [CW-1:0] BLOCK_N = CW'(BIAS_BLOCK);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_FILT  = 3'd2;
  localparam logic [2:0] S_BIAS  = 3'd3;
  localparam logic [2:0] S_BDIV  = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_CDIV  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]               state_q, state_d;
  logic                     in_acc, out_free;
  logic                     mac_done;
  logic signed [ACC_W-1:0]  mac_acc, adj, shq;
  logic signed [FILT_W-1:0] filt_d, filt_q, bias_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]         sum_mag;
  logic [CW-1:0]            count_q;
  logic signed [FILT_W:0]   diff;
  logic [FILT_W:0]          diff_mag;
  logic [DIV_W-1:0]         mag25_q, div_x, div_quo;
  logic                     neg_q, cstart_q, div_done;
  logic [FILT_W-1:0]        bq;
  logic [CENT_W-1:0]        cq;
  logic signed [CENT_W-1:0] cent_q;
  div_req_t                 div_req;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;

  fird_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .sample_i (sample_i),
    .done_o   (mac_done),
    .acc_o    (mac_acc)
  );

  // Divider requests: the bias on a block-closing word, then the scale.
  assign div_req.start = ((state_q == S_BIAS) && (count_q == BLOCK_N)) || cstart_q;
  assign div_req.sel   = cstart_q ? DIV_SEL_SCALE : DIV_SEL_BIAS;
  assign sum_mag       = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_x         = cstart_q ? mag25_q : DIV_W'(sum_mag);

  fird_cdiv #(
    .BIAS_BLOCK (BIAS_BLOCK)
  ) u_cdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .x_i    (div_x),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Drop the Q1.15 fraction toward zero and saturate.
  assign adj = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'(Q_ROUND) : ACC_W'(0));
  assign shq = adj >>> Q_SHIFT;
  always_comb begin
    if (shq > F_HI) begin
      filt_d = FILT_W'(FILT_MAX);
    end else if (shq < F_LO) begin
      filt_d = FILT_W'(FILT_MIN);
    end else begin
      filt_d = shq[FILT_W-1:0];
    end
  end

  // Difference to the bias and its magnitude.
  assign diff     = (FILT_W+1)'(filt_q) - (FILT_W+1)'(bias_q);
  assign diff_mag = diff[FILT_W] ? (FILT_W+1)'(-diff) : (FILT_W+1)'(diff);
  assign bq       = FILT_W'(div_quo);
  assign cq       = CENT_W'(div_quo);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MAC;
      S_MAC:   if (mac_done) state_d = S_FILT;
      S_FILT:  state_d = S_BIAS;
      S_BIAS:  state_d = (count_q == BLOCK_N) ? S_BDIV : S_SCALE;
      S_BDIV:  if (div_done) state_d = S_SCALE;
      S_SCALE: state_d = S_CDIV;
      S_CDIV:  if (div_done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cstart_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cstart_q <= (state_q == S_SCALE);
    end
  end

  // Bias block: sum filtered words, then replace the bias with the mean.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      bias_q  <= '0;
    end else if ((state_q == S_BIAS) && (count_q != BLOCK_N)) begin
      sum_q   <= sum_q + SUM_W'(filt_q);
      count_q <= count_q + 1'b1;
    end else if ((state_q == S_BDIV) && div_done) begin
      bias_q  <= sum_q[SUM_W-1] ? -bq : bq;
      sum_q   <= '0;
      count_q <= '0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_FILT) begin
      filt_q <= filt_d;
    end
    if (state_q == S_SCALE) begin
      neg_q   <= diff[FILT_W];
      mag25_q <= DIV_W'(diff_mag) * DIV_W'(SCALE_NUM);
    end
    if ((state_q == S_CDIV) && div_done) begin
      cent_q <= neg_q ? -cq : cq;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      filtered_o <= filt_q;
      bias_o     <= bias_q;
      centered_o <= cent_q;
    end
  end

endmodule
`default_nettype wire
